### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by all design and verification files.
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF          = 16;
  localparam int ITEM_WIDTH_DEF     = 32;
  localparam int PRIORITY_WIDTH_DEF = 8;

  // count and capacity fields are five bits wide
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_CLR = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;  // insert the new entry, shift larger ones toward the tail
    logic deq;  // shift every entry one place toward the head
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and swaps data with its neighbors.
// Depends on spq_pkg.
`default_nettype none
module spq_cell #(
  parameter int ITEM_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  wire                       clk,
  input  spq_pkg::cell_ctl_t        ctl,
  input  wire                       occ,
  input  wire                       left_occ,
  input  wire                       left_gt,
  input  wire  [ITEM_WIDTH-1:0]     left_item,
  input  wire  [PRIORITY_WIDTH-1:0] left_prio,
  input  wire  [ITEM_WIDTH-1:0]     right_item,
  input  wire  [PRIORITY_WIDTH-1:0] right_prio,
  input  wire  [ITEM_WIDTH-1:0]     new_item,
  input  wire  [PRIORITY_WIDTH-1:0] new_prio,
  output logic [ITEM_WIDTH-1:0]     item,
  output logic [PRIORITY_WIDTH-1:0] prio,
  output logic                      gt
);
  import spq_pkg::*;

  // strictly larger: equal priorities keep arrival order
  assign gt = occ && (prio > new_prio);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (left_gt) begin
        item <= left_item;
        prio <= left_prio;
      end else if (gt || (!occ && left_occ)) begin
        item <= new_item;
        prio <= new_prio;
      end
    end else if (ctl.deq) begin
      item <= right_item;
      prio <= right_prio;
    end
  end

endmodule
`default_nettype wire

### rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain, count, result register.
// Depends on spq_pkg and spq_cell.
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid / in_ready    mode, item, priority_req
// res      res_valid / res_ready  out_item, out_valid, status, head_item,
//                                 head_priority, count, empty_res, full_res
// cfg      cfg_valid / cfg_ready  cfg_data (capacity)
//
// One operation per cycle unless the result stalls: every cell compares against
// the new priority at once and all shift together, and the result is registered
// on the input transfer. A result register parts the two sides; a new input is
// taken while the result is taken in the same cycle. Synchronous reset empties the
// queue and sets capacity to 16. A stalled result holds input off.
module sorted_priority_queue_top #(
  parameter int DEPTH          = spq_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH     = spq_pkg::ITEM_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [1:0]                 mode,
  input  wire  [ITEM_WIDTH-1:0]      item,
  input  wire  [PRIORITY_WIDTH-1:0]  priority_req,
  output logic                       res_valid,
  input  wire                        res_ready,
  output logic [ITEM_WIDTH-1:0]      out_item,
  output logic                       out_valid,
  output logic [1:0]                 status,
  output logic [ITEM_WIDTH-1:0]      head_item,
  output logic [PRIORITY_WIDTH-1:0]  head_priority,
  output logic [spq_pkg::CNT_W-1:0]  count,
  output logic                       empty_res,
  output logic                       full_res,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [spq_pkg::CNT_W-1:0]  cfg_data
);
  import spq_pkg::*;

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  mode_t            op;
  logic             enq_ok;
  logic             deq_ok;
  status_t          status_next;
  cell_ctl_t        ctl;

  logic [ITEM_WIDTH-1:0]     cell_item [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]          cell_gt;
  logic [DEPTH-1:0]          cell_occ;

  assign cfg_ready = 1'b1;
  assign in_ready  = !res_valid || res_ready;
  assign accept    = in_valid && in_ready;
  assign op        = mode_t'(mode);

  // clamp capacity to the chain length
  assign cap_eff = ({27'd0, capacity} > 32'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // decode the operation; refuse enqueue at or above capacity
  always_comb begin
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    status_next = STAT_OK;
    count_next  = count;
    case (op)
      MODE_ENQ: begin
        if (count >= cap_eff) begin
          status_next = STAT_FULL;
        end else begin
          enq_ok     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_DEQ: begin
        if (count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          deq_ok     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      MODE_CLR: count_next = '0;
      default:  count_next = count;
    endcase
  end

  assign ctl.enq = accept && enq_ok;
  assign ctl.deq = accept && deq_ok;

  // cell chain: occupancy follows from the count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_occ;
    logic                      l_gt;
    logic [ITEM_WIDTH-1:0]     l_item;
    logic [PRIORITY_WIDTH-1:0] l_prio;
    logic [ITEM_WIDTH-1:0]     r_item;
    logic [PRIORITY_WIDTH-1:0] r_prio;

    assign cell_occ[i] = {27'd0, count} > 32'(i);

    if (i == 0) begin : g_head
      assign l_occ  = 1'b1;
      assign l_gt   = 1'b0;
      assign l_item = item;
      assign l_prio = priority_req;
    end else begin : g_body
      assign l_occ  = cell_occ[i-1];
      assign l_gt   = cell_gt[i-1];
      assign l_item = cell_item[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_item = '0;
      assign r_prio = '0;
    end else begin : g_mid
      assign r_item = cell_item[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell #(
      .ITEM_WIDTH     (ITEM_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (cell_occ[i]),
      .left_occ   (l_occ),
      .left_gt    (l_gt),
      .left_item  (l_item),
      .left_prio  (l_prio),
      .right_item (r_item),
      .right_prio (r_prio),
      .new_item   (item),
      .new_prio   (priority_req),
      .item       (cell_item[i]),
      .prio       (cell_prio[i]),
      .gt         (cell_gt[i])
    );
  end

  // count and result flags advance with each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
      status    <= STAT_OK;
      empty_res <= 1'b1;
      full_res  <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
        out_valid <= deq_ok;
        status    <= status_next;
        empty_res <= (count_next == '0);
        full_res  <= (count_next >= cap_eff);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // dequeued payload: the head before the shift
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= deq_ok ? cell_item[0] : '0;
    end
  end

  // cells only move on a transfer, so the head always matches the held result
  assign head_item     = (count != '0) ? cell_item[0] : '0;
  assign head_priority = (count != '0) ? cell_prio[0] : '0;

endmodule
`default_nettype wire

### verif/spq_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted priority queue: tracks the queue contents and capacity,
// predicts each result and compares it field by field. Depends on spq_pkg.
module spq_checker
  import spq_pkg::*;
(
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire                           in_ready,
  input  wire  [1:0]                    mode,
  input  wire  [ITEM_WIDTH_DEF-1:0]     item,
  input  wire  [PRIORITY_WIDTH_DEF-1:0] priority_req,
  input  wire                           res_valid,
  input  wire                           res_ready,
  input  wire  [ITEM_WIDTH_DEF-1:0]     out_item,
  input  wire                           out_valid,
  input  wire  [1:0]                    status,
  input  wire  [ITEM_WIDTH_DEF-1:0]     head_item,
  input  wire  [PRIORITY_WIDTH_DEF-1:0] head_priority,
  input  wire  [CNT_W-1:0]              count,
  input  wire                           empty_res,
  input  wire                           full_res,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire  [CNT_W-1:0]              cfg_data,
  output wire  [31:0]                   mismatches,
  output wire  [31:0]                   outstanding
);

  localparam int IW = ITEM_WIDTH_DEF;
  localparam int PW = PRIORITY_WIDTH_DEF;

  typedef struct {
    logic [IW-1:0]    removed;
    logic             removed_valid;
    status_t          stat;
    logic [IW-1:0]    head;
    logic [PW-1:0]    head_prio;
    logic [CNT_W-1:0] held;
    logic             is_empty;
    logic             is_full;
  } queue_report_t;

  logic [IW-1:0]    slot_item [DEPTH_DEF];
  logic [PW-1:0]    slot_prio [DEPTH_DEF];
  int               held_count = 0;
  logic [CNT_W-1:0] cap_reg = CAPACITY_RESET;
  queue_report_t    due_reports[$];
  int               fault_count = 0;
  int               owed = 0;

  assign mismatches  = fault_count;
  assign outstanding = owed;

  task automatic report_fault(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fault_count++;
  endtask

  // Apply one operation to the tracked queue and return the result it produces.
  function automatic queue_report_t step_sorted_queue(input logic [1:0] op,
                                                      input logic [IW-1:0] it,
                                                      input logic [PW-1:0] pr);
    queue_report_t r;
    int lim;
    int pos;
    lim = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
    r.removed       = '0;
    r.removed_valid = 1'b0;
    r.stat          = STAT_OK;
    case (op)
      MODE_ENQ: begin
        if (held_count >= lim) begin
          r.stat = STAT_FULL;
        end else begin
          // new entry lands after every entry of lower or equal priority
          pos = 0;
          while (pos < held_count && slot_prio[pos] <= pr) pos++;
          for (int i = held_count; i > pos; i--) begin
            slot_item[i] = slot_item[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_item[pos] = it;
          slot_prio[pos] = pr;
          held_count++;
        end
      end
      MODE_DEQ: begin
        if (held_count == 0) begin
          r.stat = STAT_EMPTY;
        end else begin
          r.removed       = slot_item[0];
          r.removed_valid = 1'b1;
          for (int i = 1; i < held_count; i++) begin
            slot_item[i-1] = slot_item[i];
            slot_prio[i-1] = slot_prio[i];
          end
          held_count--;
        end
      end
      MODE_CLR: held_count = 0;
      default: ;
    endcase
    r.head      = (held_count != 0) ? slot_item[0] : '0;
    r.head_prio = (held_count != 0) ? slot_prio[0] : '0;
    r.held      = CNT_W'(held_count);
    r.is_empty  = (held_count == 0);
    r.is_full   = (held_count >= lim);
    return r;
  endfunction

  task automatic check_report();
    queue_report_t want;
    if (due_reports.size() == 0) begin
      report_fault("result transfer with no operation outstanding");
      return;
    end
    want = due_reports.pop_front();
    if (out_item !== want.removed)
      report_fault($sformatf("out_item got %h, wanted %h", out_item, want.removed));
    if (out_valid !== want.removed_valid)
      report_fault($sformatf("out_valid got %b, wanted %b", out_valid, want.removed_valid));
    if (status !== want.stat)
      report_fault($sformatf("status got %0d, wanted %0d", status, want.stat));
    if (head_item !== want.head)
      report_fault($sformatf("head_item got %h, wanted %h", head_item, want.head));
    if (head_priority !== want.head_prio)
      report_fault($sformatf("head_priority got %h, wanted %h", head_priority,
                             want.head_prio));
    if (count !== want.held)
      report_fault($sformatf("count got %0d, wanted %0d", count, want.held));
    if (empty_res !== want.is_empty)
      report_fault($sformatf("empty_res got %b, wanted %b", empty_res, want.is_empty));
    if (full_res !== want.is_full)
      report_fault($sformatf("full_res got %b, wanted %b", full_res, want.is_full));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      cap_reg    = CAPACITY_RESET;
      due_reports.delete();
    end else begin
      if (res_valid && res_ready) check_report();
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (in_valid && in_ready)
        due_reports.push_back(step_sorted_queue(mode, item, priority_req));
    end
    owed = due_reports.size();
  end

endmodule

### verif/tb_sorted_priority_queue_top.sv
`timescale 1ns / 100ps
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
// Depends on spq_pkg, sorted_priority_queue_top and spq_checker.
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  wire                           in_ready;
  logic [1:0]                    mode = MODE_ENQ;
  logic [ITEM_WIDTH_DEF-1:0]     item = '0;
  logic [PRIORITY_WIDTH_DEF-1:0] priority_req = '0;
  wire                           res_valid;
  logic                          res_ready = 1'b0;
  wire  [ITEM_WIDTH_DEF-1:0]     out_item;
  wire                           out_valid;
  wire  [1:0]                    status;
  wire  [ITEM_WIDTH_DEF-1:0]     head_item;
  wire  [PRIORITY_WIDTH_DEF-1:0] head_priority;
  wire  [CNT_W-1:0]              count;
  wire                           empty_res;
  wire                           full_res;
  logic                          cfg_valid = 1'b0;
  wire                           cfg_ready;
  logic [CNT_W-1:0]              cfg_data = '0;
  wire  [31:0]                   mismatches;
  wire  [31:0]                   outstanding;

  // steady: suppress random idling on both sides
  // stall_request: ask the result sink for one long hold-off
  bit steady = 1'b0;
  bit stall_request = 1'b0;

  sorted_priority_queue_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .item         (item),
    .priority_req (priority_req),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_item     (out_item),
    .out_valid    (out_valid),
    .status       (status),
    .head_item    (head_item),
    .head_priority(head_priority),
    .count        (count),
    .empty_res    (empty_res),
    .full_res     (full_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  spq_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .item         (item),
    .priority_req (priority_req),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_item     (out_item),
    .out_valid    (out_valid),
    .status       (status),
    .head_item    (head_item),
    .head_priority(head_priority),
    .count        (count),
    .empty_res    (empty_res),
    .full_res     (full_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Result sink: drive res_ready at the falling edge. Idle at random unless in a
  // steady stretch; on request, hold off for a long run of cycles so the result
  // register backs up and the block stalls its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold_left = 80;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= steady || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Watchdog: count cycles and end the run if it never finishes.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one operation. Insert random idle cycles first, then hold valid and
  // payload until the transfer happens at a rising edge.
  task automatic send_op(input mode_t op, input logic [ITEM_WIDTH_DEF-1:0] it,
                         input logic [PRIORITY_WIDTH_DEF-1:0] pr);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= op;
    item         <= it;
    priority_req <= pr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write the capacity register once every outstanding result has drained.
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random phase at one capacity. enq_pct weights enqueues to reach the full
  // state; narrow_prio squeezes priorities into a few values to force ties.
  task automatic run_phase(input logic [CNT_W-1:0] cap, input int n_ops,
                           input int enq_pct, input bit narrow_prio,
                           input int hold_at);
    mode_t op;
    int    r;
    write_capacity(cap);
    for (int k = 0; k < n_ops; k++) begin
      if (k == hold_at) stall_request = 1'b1;
      r = $urandom_range(0, 99);
      if (r < enq_pct)  op = MODE_ENQ;
      else if (r < 94)  op = MODE_DEQ;
      else if (r < 97)  op = MODE_CLR;
      else              op = MODE_NOP;
      send_op(op, $urandom(),
              narrow_prio ? PRIORITY_WIDTH_DEF'($urandom_range(0, 3))
                          : PRIORITY_WIDTH_DEF'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset capacity: empty dequeue, idle mode, extremes of
    // item and priority, ties at head and in the middle, then clear.
    send_op(MODE_DEQ, '0, '0);
    send_op(MODE_NOP, '0, '0);
    send_op(MODE_ENQ, 32'hFFFF_FFFF, 8'hFF);
    send_op(MODE_ENQ, 32'h0000_0000, 8'h00);
    send_op(MODE_ENQ, 32'hA5A5_0001, 8'h80);
    send_op(MODE_ENQ, 32'h5A5A_0002, 8'h80);
    send_op(MODE_ENQ, 32'h1234_5678, 8'h00);
    send_op(MODE_NOP, 32'hFFFF_FFFF, 8'hFF);
    send_op(MODE_DEQ, '0, '0);
    send_op(MODE_DEQ, '0, '0);
    send_op(MODE_DEQ, '0, '0);
    send_op(MODE_CLR, '0, '0);
    send_op(MODE_DEQ, '0, '0);

    // Capacity one: fill, refuse, drain.
    write_capacity(5'd1);
    send_op(MODE_ENQ, 32'h0000_0005, 8'h07);
    send_op(MODE_ENQ, 32'h0000_0006, 8'h01);
    send_op(MODE_DEQ, '0, '0);

    // Capacity zero: always full, every enqueue refused.
    write_capacity(5'd0);
    send_op(MODE_ENQ, 32'hDEAD_BEEF, 8'h10);

    // Capacity above depth clamps; then lower it below the count held.
    write_capacity(5'd31);
    send_op(MODE_ENQ, 32'h0000_0011, 8'h30);
    send_op(MODE_ENQ, 32'h0000_0022, 8'h20);
    send_op(MODE_ENQ, 32'h0000_0033, 8'h10);
    write_capacity(5'd2);
    send_op(MODE_ENQ, 32'h0000_0044, 8'h00);
    send_op(MODE_DEQ, '0, '0);
    send_op(MODE_DEQ, '0, '0);
    send_op(MODE_CLR, '0, '0);

    // Random part: open with a stretch free of idling, then hold the receiver
    // off once while the sender keeps offering.
    steady = 1'b1;
    run_phase(5'd16, 150, 65, 1'b0, -1);
    steady = 1'b0;
    run_phase(5'd16, 250, 60, 1'b0, 60);
    run_phase(5'd1, 120, 45, 1'b0, -1);
    run_phase(5'd31, 250, 62, 1'b0, -1);
    run_phase(5'd0, 30, 50, 1'b0, -1);
    run_phase(5'd5, 200, 55, 1'b1, -1);
    run_phase(5'd3, 150, 50, 1'b1, -1);
    run_phase(CNT_W'($urandom_range(0, 31)), 150, 55, 1'b0, -1);
    run_phase(5'd16, 150, 62, 1'b1, -1);

    // Drop valid, drain every outstanding result, then allow a few more cycles.
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
